FILE: hdl/adctw_pkg.sv
`timescale 1ns / 1ps

package adctw_pkg;

   // Frame geometry
   localparam int SAMPLE_BITS  = 24;
   localparam int COMMAND_BITS = 7;
   localparam int SAMPLE_W     = 24;
   localparam int TIMEOUT_W    = 20;
   localparam int BIT_CNT_W    = 6;
   localparam int CMD_IDX_W    = $clog2(COMMAND_BITS);
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RESET  = TIMEOUT_W'(50000);
   localparam logic [COMMAND_BITS-1:0] WR_CMD_RESET   = COMMAND_BITS'(101);
   localparam logic [COMMAND_BITS-1:0] RD_CMD_RESET   = COMMAND_BITS'(86);

   // Register indexes (word address)
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_WR_CMD  = 2'd1;
   localparam logic [1:0] REG_RD_CMD  = 2'd2;

   // Request codes
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_READ     = 3'd1;
   localparam logic [2:0] OP_READ_NB  = 3'd2;
   localparam logic [2:0] OP_WRITE_CFG = 3'd3;
   localparam logic [2:0] OP_READ_CFG = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_WAIT  = 4'd1,
      PH_FRAME = 4'd2,
      PH_TAIL  = 4'd3,
      PH_PRE   = 4'd4,
      PH_CMD   = 4'd5,
      PH_GAP   = 4'd6,
      PH_WBYTE = 4'd7,
      PH_RBYTE = 4'd8,
      PH_FIN   = 4'd9
   } phase_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] config_byte;
      logic       dout_level;
   } req_item_type;

   typedef struct packed {
      logic                       sclk_level;
      logic                       data_drive_enable;
      logic                       data_drive_value;
      logic                       busy_res;
      logic                       done_res;
      logic                       success;
      logic signed [SAMPLE_W-1:0] sample;
      logic [7:0]                 config_value;
   } rsp_item_type;

   // Length of each phase in serial clocks
   function automatic logic [BIT_CNT_W-1:0] phase_len(input phase_type ph);
      logic [BIT_CNT_W-1:0] len;
      case (ph)
         PH_FRAME: len = BIT_CNT_W'(SAMPLE_BITS);
         PH_TAIL:  len = BIT_CNT_W'(3);
         PH_PRE:   len = BIT_CNT_W'(2);
         PH_CMD:   len = BIT_CNT_W'(COMMAND_BITS);
         PH_WBYTE: len = BIT_CNT_W'(8);
         PH_RBYTE: len = BIT_CNT_W'(8);
         default:  len = BIT_CNT_W'(1);
      endcase
      return len;
   endfunction

   // Command bit j, MSB first; zero beyond the command
   function automatic logic cmd_bit(input logic [COMMAND_BITS-1:0] cmd,
                                    input logic [BIT_CNT_W-1:0]    j);
      logic [CMD_IDX_W-1:0] idx;
      logic                 b;
      idx = CMD_IDX_W'(COMMAND_BITS - 1) - j[CMD_IDX_W-1:0];
      if (j >= BIT_CNT_W'(COMMAND_BITS)) begin
         b = 1'b0;
      end else begin
         b = cmd[idx];
      end
      return b;
   endfunction

   // Byte bit j, MSB first
   function automatic logic byte_bit(input logic [7:0]           data,
                                     input logic [BIT_CNT_W-1:0] j);
      logic [2:0] idx;
      idx = 3'd7 - j[2:0];
      return data[idx];
   endfunction

endpackage

FILE: hdl/adc_two_wire_serial_master.sv
`timescale 1ns / 1ps
// A result is held in the output register from the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless the output stalls; each is one half serial clock
//   period; the sequencer makes a single pass of logic between state and output registers.
// Reset (synchronous, active high) returns the sequencer to idle, clears its counters and
//   restores timeout 50000, write command 101 and read command 86.
module adc_two_wire_serial_master (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  adctw_pkg::req_item_type               req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output adctw_pkg::rsp_item_type               rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [adctw_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [adctw_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [adctw_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);

   // Configuration registers
   logic [adctw_pkg::TIMEOUT_W-1:0]    timeout_ff;
   logic [adctw_pkg::COMMAND_BITS-1:0] wr_cmd_ff;
   logic [adctw_pkg::COMMAND_BITS-1:0] rd_cmd_ff;

   // Sequencer state
   adctw_pkg::phase_type               phase_ff, phase_in;
   logic [2:0]                         op_ff, op_in;
   logic [adctw_pkg::BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic                               high_ff, high_in;
   logic [adctw_pkg::SAMPLE_W-1:0]     shift_ff, shift_in;
   logic [adctw_pkg::TIMEOUT_W-1:0]    wait_cnt_ff, wait_cnt_in;
   logic [7:0]                         byte_ff, byte_in;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in;
   adctw_pkg::rsp_item_type            rsp_ff, rsp_in;

   logic                               accept;
   logic                               csr_write;
   logic [adctw_pkg::TIMEOUT_W-1:0]    wcnt;
   logic [adctw_pkg::COMMAND_BITS-1:0] cmd;
   logic [adctw_pkg::BIT_CNT_W-1:0]    k, k_next;
   logic                               hi;
   logic                               en, val;
   logic [adctw_pkg::SAMPLE_W-1:0]     sample_ext;

   // Handshake: take a transaction whenever the output register is free or draining
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      case (paddr[3:2])
         adctw_pkg::REG_TIMEOUT:
            prdata = adctw_pkg::CSR_DATA_W'(timeout_ff);
         adctw_pkg::REG_WR_CMD:
            prdata = adctw_pkg::CSR_DATA_W'(wr_cmd_ff);
         adctw_pkg::REG_RD_CMD:
            prdata = adctw_pkg::CSR_DATA_W'(rd_cmd_ff);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= adctw_pkg::TIMEOUT_RESET;
         wr_cmd_ff  <= adctw_pkg::WR_CMD_RESET;
         rd_cmd_ff  <= adctw_pkg::RD_CMD_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            adctw_pkg::REG_TIMEOUT: timeout_ff <= pwdata[adctw_pkg::TIMEOUT_W-1:0];
            adctw_pkg::REG_WR_CMD:  wr_cmd_ff  <= pwdata[adctw_pkg::COMMAND_BITS-1:0];
            adctw_pkg::REG_RD_CMD:  rd_cmd_ff  <= pwdata[adctw_pkg::COMMAND_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sign-extend the captured frame
   always_comb begin
      for (int i = 0; i < adctw_pkg::SAMPLE_W; i++) begin
         sample_ext[i] = (i < adctw_pkg::SAMPLE_BITS) ? shift_ff[i]
                                                      : shift_ff[adctw_pkg::SAMPLE_BITS-1];
      end
   end

   assign cmd    = (op_ff == adctw_pkg::OP_READ_CFG) ? rd_cmd_ff : wr_cmd_ff;
   assign k      = bit_cnt_ff;
   assign k_next = bit_cnt_ff + adctw_pkg::BIT_CNT_W'(1);
   assign hi     = ~high_ff;
   assign wcnt   = (phase_ff == adctw_pkg::PH_WAIT) ? wait_cnt_ff : '0;

   // Next state and result for one half period
   always_comb begin
      phase_in    = phase_ff;
      op_in       = op_ff;
      bit_cnt_in  = bit_cnt_ff;
      high_in     = high_ff;
      shift_in    = shift_ff;
      wait_cnt_in = wait_cnt_ff;
      byte_in     = byte_ff;
      rsp_in      = '0;
      en          = 1'b0;
      val         = 1'b0;

      case (phase_ff)
         adctw_pkg::PH_WAIT,
         adctw_pkg::PH_IDLE: begin
            // Latch a new request while idle
            if (phase_ff == adctw_pkg::PH_IDLE) begin
               if (req_data.req_type == adctw_pkg::OP_READ_NB) begin
                  op_in = adctw_pkg::OP_READ_NB;
               end else if (req_data.req_type == adctw_pkg::OP_READ ||
                            req_data.req_type == adctw_pkg::OP_WRITE_CFG ||
                            req_data.req_type == adctw_pkg::OP_READ_CFG) begin
                  op_in       = req_data.req_type;
                  wait_cnt_in = '0;
                  phase_in    = adctw_pkg::PH_WAIT;
                  if (req_data.req_type == adctw_pkg::OP_WRITE_CFG) begin
                     byte_in = req_data.config_byte;
                  end
               end
            end
            // Wait for data-ready low, or fail
            if (phase_ff == adctw_pkg::PH_WAIT || phase_in == adctw_pkg::PH_WAIT ||
                (phase_ff == adctw_pkg::PH_IDLE &&
                 req_data.req_type == adctw_pkg::OP_READ_NB)) begin
               if (!req_data.dout_level) begin
                  phase_in        = adctw_pkg::PH_FRAME;
                  bit_cnt_in      = '0;
                  high_in         = 1'b0;
                  shift_in        = '0;
                  rsp_in.busy_res = 1'b1;
               end else if (phase_ff == adctw_pkg::PH_IDLE &&
                            req_data.req_type == adctw_pkg::OP_READ_NB) begin
                  rsp_in.done_res = 1'b1;
               end else if (wcnt >= timeout_ff) begin
                  phase_in        = adctw_pkg::PH_IDLE;
                  rsp_in.done_res = 1'b1;
               end else begin
                  wait_cnt_in     = wcnt + adctw_pkg::TIMEOUT_W'(1);
                  rsp_in.busy_res = 1'b1;
               end
            end
         end

         adctw_pkg::PH_FRAME,
         adctw_pkg::PH_TAIL,
         adctw_pkg::PH_PRE,
         adctw_pkg::PH_CMD,
         adctw_pkg::PH_GAP,
         adctw_pkg::PH_WBYTE,
         adctw_pkg::PH_RBYTE,
         adctw_pkg::PH_FIN: begin
            rsp_in.sclk_level = hi;
            rsp_in.busy_res   = 1'b1;

            // Drive the data line; it changes at the falling edge
            case (phase_ff)
               adctw_pkg::PH_PRE: begin
                  en = 1'b1;
               end
               adctw_pkg::PH_CMD: begin
                  en  = 1'b1;
                  val = hi ? ((k == '0) ? 1'b0 :
                              adctw_pkg::cmd_bit(cmd, k - adctw_pkg::BIT_CNT_W'(1)))
                           : adctw_pkg::cmd_bit(cmd, k);
               end
               adctw_pkg::PH_GAP: begin
                  en  = 1'b1;
                  val = adctw_pkg::cmd_bit(cmd,
                           adctw_pkg::BIT_CNT_W'(adctw_pkg::COMMAND_BITS - 1));
               end
               adctw_pkg::PH_WBYTE: begin
                  en  = 1'b1;
                  val = hi ? ((k == '0) ?
                              adctw_pkg::cmd_bit(cmd,
                                 adctw_pkg::BIT_CNT_W'(adctw_pkg::COMMAND_BITS - 1)) :
                              adctw_pkg::byte_bit(byte_ff, k - adctw_pkg::BIT_CNT_W'(1)))
                           : adctw_pkg::byte_bit(byte_ff, k);
               end
               adctw_pkg::PH_FIN: begin
                  if (op_ff == adctw_pkg::OP_WRITE_CFG) begin
                     en  = 1'b1;
                     val = adctw_pkg::byte_bit(byte_ff, adctw_pkg::BIT_CNT_W'(7));
                  end
               end
               default: ;
            endcase
            rsp_in.data_drive_enable = en;
            rsp_in.data_drive_value  = val;

            if (hi) begin
               // High half: sample the line
               if (phase_ff == adctw_pkg::PH_FRAME) begin
                  shift_in = {shift_ff[adctw_pkg::SAMPLE_W-2:0], req_data.dout_level};
               end else if (phase_ff == adctw_pkg::PH_RBYTE) begin
                  byte_in = {byte_ff[6:0], req_data.dout_level};
               end
               high_in = 1'b1;
            end else begin
               // Low half: advance the bit count and the phase
               high_in    = 1'b0;
               bit_cnt_in = k_next;
               if (k_next >= adctw_pkg::phase_len(phase_ff)) begin
                  bit_cnt_in = '0;
                  case (phase_ff)
                     adctw_pkg::PH_FRAME: phase_in = adctw_pkg::PH_TAIL;
                     adctw_pkg::PH_TAIL: begin
                        if (op_ff == adctw_pkg::OP_WRITE_CFG ||
                            op_ff == adctw_pkg::OP_READ_CFG) begin
                           phase_in = adctw_pkg::PH_PRE;
                        end else begin
                           phase_in        = adctw_pkg::PH_IDLE;
                           rsp_in.busy_res = 1'b0;
                           rsp_in.done_res = 1'b1;
                           rsp_in.success  = 1'b1;
                           rsp_in.sample   = sample_ext;
                        end
                     end
                     adctw_pkg::PH_PRE: phase_in = adctw_pkg::PH_CMD;
                     adctw_pkg::PH_CMD: phase_in = adctw_pkg::PH_GAP;
                     adctw_pkg::PH_GAP: begin
                        if (op_ff == adctw_pkg::OP_WRITE_CFG) begin
                           phase_in = adctw_pkg::PH_WBYTE;
                        end else begin
                           byte_in  = '0;
                           phase_in = adctw_pkg::PH_RBYTE;
                        end
                     end
                     adctw_pkg::PH_WBYTE,
                     adctw_pkg::PH_RBYTE: phase_in = adctw_pkg::PH_FIN;
                     default: begin
                        phase_in        = adctw_pkg::PH_IDLE;
                        rsp_in.busy_res = 1'b0;
                        rsp_in.done_res = 1'b1;
                        rsp_in.success  = 1'b1;
                        if (op_ff == adctw_pkg::OP_READ_CFG) begin
                           rsp_in.config_value = byte_ff;
                        end
                     end
                  endcase
               end
            end
         end

         default: begin
            // Unused phase codes drop back to idle
            phase_in = adctw_pkg::PH_IDLE;
         end
      endcase
   end

   // Output valid: set on a transaction, drop when taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= adctw_pkg::PH_IDLE;
         op_ff        <= adctw_pkg::OP_NONE;
         bit_cnt_ff   <= '0;
         high_ff      <= 1'b0;
         shift_ff     <= '0;
         wait_cnt_ff  <= '0;
         byte_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            op_ff       <= op_in;
            bit_cnt_ff  <= bit_cnt_in;
            high_ff     <= high_in;
            shift_ff    <= shift_in;
            wait_cnt_ff <= wait_cnt_in;
            byte_ff     <= byte_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Every accepted transaction leaves a result in the output register
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   // Success is only reported with done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.success |-> rsp_ff.done_res && !rsp_ff.busy_res)
      else $error("success without done");

   // Between requests the bit position is at rest
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == adctw_pkg::PH_IDLE || phase_ff == adctw_pkg::PH_WAIT) |->
         (bit_cnt_ff == '0 && !high_ff))
      else $error("bit counter not at rest outside a frame");

   // The master only drives the data line for configuration accesses
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.data_drive_enable |->
         (op_ff == adctw_pkg::OP_WRITE_CFG || op_ff == adctw_pkg::OP_READ_CFG))
      else $error("data line driven during a plain read");

endmodule

FILE: verif/tb_adc_two_wire_serial_master.sv
`timescale 1ns / 1ps

module tb_adc_two_wire_serial_master;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 600;
   localparam int GAP_PERCENT  = 26;
   localparam int REPORT_LIMIT = 10;
   localparam int MAX_TIMEOUT_TRIAL = 30;

   // Request codes that the block has no meaning for
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [1:0]     reg_idx;
      logic [19:0]    reg_val;
      logic [2:0]     op;
      logic [7:0]     cfg;
      logic [15:0]    wait_hi;
      logic [23:0]    word;
      logic [7:0]     rbyte;
      logic           typed;
      logic           exp_ok;
      logic [23:0]    exp_sample;
      logic [7:0]     exp_cfg;
   } plan_row_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   adctw_pkg::req_item_type          req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   adctw_pkg::rsp_item_type          rsp_data;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [adctw_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [adctw_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [adctw_pkg::CSR_DATA_W-1:0] prdata;
   logic                             pready;

   // Shadow of the sequencer and its registers
   adctw_pkg::phase_type  seq_ph = adctw_pkg::PH_IDLE;
   logic [2:0]            op_held = '0;
   logic [5:0]            bit_idx = '0;
   logic                  in_high = 1'b0;
   logic [23:0]           shift_acc = '0;
   logic [19:0]           wait_cnt = '0;
   logic [7:0]            byte_acc = '0;
   logic [19:0]           timeout_cfg = adctw_pkg::TIMEOUT_RESET;
   logic [6:0]            wr_cmd_cfg = adctw_pkg::WR_CMD_RESET;
   logic [6:0]            rd_cmd_cfg = adctw_pkg::RD_CMD_RESET;

   adctw_pkg::rsp_item_type pins_due[$];
   plan_row_type          plan_rows[$];
   logic                  gaps_enabled = 1'b1;
   logic                  typed_on = 1'b0;
   logic                  typed_ok = 1'b0;
   logic [23:0]           typed_sample = '0;
   logic [7:0]            typed_cfg = '0;
   int                    live_items = 0;
   int                    mismatch_count = 0;
   int                    results_seen = 0;
   int                    cycle_count = 0;

   adc_two_wire_serial_master dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Serial clocks spent in each phase
   function automatic int span_of(adctw_pkg::phase_type p);
      case (p)
         adctw_pkg::PH_FRAME: return adctw_pkg::SAMPLE_BITS;
         adctw_pkg::PH_TAIL:  return 3;
         adctw_pkg::PH_PRE:   return 2;
         adctw_pkg::PH_CMD:   return adctw_pkg::COMMAND_BITS;
         adctw_pkg::PH_WBYTE: return 8;
         adctw_pkg::PH_RBYTE: return 8;
         default:             return 1;
      endcase
   endfunction

   // Command bit j of the code for the current access, MSB first
   function automatic logic command_bit(int j);
      logic [adctw_pkg::COMMAND_BITS-1:0] code;
      code = (op_held == adctw_pkg::OP_READ_CFG) ? rd_cmd_cfg : wr_cmd_cfg;
      if (j >= adctw_pkg::COMMAND_BITS) return 1'b0;
      return code[adctw_pkg::COMMAND_BITS-1-j];
   endfunction

   function automatic logic byte_of(int j);
      return byte_acc[7 - (j % 8)];
   endfunction

   function automatic void begin_frame();
      seq_ph = adctw_pkg::PH_FRAME;
      bit_idx = '0;
      in_high = 1'b0;
      shift_acc = '0;
   endfunction

   // One tick of waiting for data-ready low
   function automatic adctw_pkg::rsp_item_type wait_step(logic d);
      adctw_pkg::rsp_item_type r;
      r = '0;
      if (!d) begin
         begin_frame();
         r.busy_res = 1'b1;
      end else if (wait_cnt >= timeout_cfg) begin
         seq_ph = adctw_pkg::PH_IDLE;
         r.done_res = 1'b1;
      end else begin
         wait_cnt = wait_cnt + 1'b1;
         r.busy_res = 1'b1;
      end
      return r;
   endfunction

   // Pin levels and status for one half period
   function automatic adctw_pkg::rsp_item_type predict_pins(adctw_pkg::req_item_type it);
      adctw_pkg::rsp_item_type r;
      logic         hi;
      logic         en;
      logic         dv;
      int           k;
      r = '0;
      en = 1'b0;
      dv = 1'b0;
      if (seq_ph == adctw_pkg::PH_WAIT) begin
         r = wait_step(it.dout_level);
      end else if (seq_ph == adctw_pkg::PH_IDLE) begin
         case (it.req_type)
            adctw_pkg::OP_READ_NB: begin
               op_held = adctw_pkg::OP_READ_NB;
               if (it.dout_level) begin
                  r.done_res = 1'b1;
               end else begin
                  begin_frame();
                  r.busy_res = 1'b1;
               end
            end
            adctw_pkg::OP_READ, adctw_pkg::OP_WRITE_CFG, adctw_pkg::OP_READ_CFG: begin
               op_held = it.req_type;
               wait_cnt = '0;
               if (it.req_type == adctw_pkg::OP_WRITE_CFG) byte_acc = it.config_byte;
               seq_ph = adctw_pkg::PH_WAIT;
               r = wait_step(it.dout_level);
            end
            default: ;
         endcase
      end else begin
         k = bit_idx;
         hi = !in_high;
         r.sclk_level = hi;
         r.busy_res = 1'b1;
         case (seq_ph)
            adctw_pkg::PH_PRE: en = 1'b1;
            adctw_pkg::PH_CMD: begin
               en = 1'b1;
               dv = hi ? (k == 0 ? 1'b0 : command_bit(k - 1)) : command_bit(k);
            end
            adctw_pkg::PH_GAP: begin
               en = 1'b1;
               dv = command_bit(adctw_pkg::COMMAND_BITS - 1);
            end
            adctw_pkg::PH_WBYTE: begin
               en = 1'b1;
               dv = hi ? (k == 0 ? command_bit(adctw_pkg::COMMAND_BITS - 1) : byte_of(k - 1))
                       : byte_of(k);
            end
            adctw_pkg::PH_FIN: begin
               if (op_held == adctw_pkg::OP_WRITE_CFG) begin
                  en = 1'b1;
                  dv = byte_of(7);
               end
            end
            default: ;
         endcase
         r.data_drive_enable = en;
         r.data_drive_value = dv;
         if (hi) begin
            // sample the line in the high half
            if (seq_ph == adctw_pkg::PH_FRAME) shift_acc = {shift_acc[22:0], it.dout_level};
            else if (seq_ph == adctw_pkg::PH_RBYTE) byte_acc = {byte_acc[6:0], it.dout_level};
            in_high = 1'b1;
         end else begin
            in_high = 1'b0;
            bit_idx = 6'(k + 1);
            if (bit_idx >= span_of(seq_ph)) begin
               bit_idx = '0;
               case (seq_ph)
                  adctw_pkg::PH_FRAME: seq_ph = adctw_pkg::PH_TAIL;
                  adctw_pkg::PH_TAIL: begin
                     if (op_held == adctw_pkg::OP_WRITE_CFG ||
                         op_held == adctw_pkg::OP_READ_CFG) begin
                        seq_ph = adctw_pkg::PH_PRE;
                     end else begin
                        seq_ph = adctw_pkg::PH_IDLE;
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                        r.success = 1'b1;
                        r.sample = shift_acc;
                     end
                  end
                  adctw_pkg::PH_PRE: seq_ph = adctw_pkg::PH_CMD;
                  adctw_pkg::PH_CMD: seq_ph = adctw_pkg::PH_GAP;
                  adctw_pkg::PH_GAP: begin
                     if (op_held == adctw_pkg::OP_WRITE_CFG) begin
                        seq_ph = adctw_pkg::PH_WBYTE;
                     end else begin
                        byte_acc = '0;
                        seq_ph = adctw_pkg::PH_RBYTE;
                     end
                  end
                  adctw_pkg::PH_WBYTE, adctw_pkg::PH_RBYTE: seq_ph = adctw_pkg::PH_FIN;
                  default: begin
                     seq_ph = adctw_pkg::PH_IDLE;
                     r.busy_res = 1'b0;
                     r.done_res = 1'b1;
                     r.success = 1'b1;
                     if (op_held == adctw_pkg::OP_READ_CFG) r.config_value = byte_acc;
                  end
               endcase
            end
         end
      end
      return r;
   endfunction

   function automatic void add_req(logic [2:0] op, logic [7:0] cfg, int wait_hi,
                                   logic [23:0] word, logic [7:0] rbyte, logic typed,
                                   logic ok, logic [23:0] smp, logic [7:0] cv);
      plan_row_type row;
      row = '0;
      row.kind = ROW_REQ;
      row.op = op;
      row.cfg = cfg;
      row.wait_hi = 16'(wait_hi);
      row.word = word;
      row.rbyte = rbyte;
      row.typed = typed;
      row.exp_ok = ok;
      row.exp_sample = smp;
      row.exp_cfg = cv;
      plan_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [1:0] idx, logic [19:0] val);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.reg_idx = idx;
      row.reg_val = val;
      plan_rows.push_back(row);
   endfunction

   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d, %s: expected %0h, got %0h", results_seen, what, want, got);
      end
   endfunction

   // Present one transaction, hold it until taken, then record its outcome
   task automatic send_tick(input adctw_pkg::req_item_type it);
      adctw_pkg::rsp_item_type due;
      while (gaps_enabled && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = predict_pins(it);
      if (due.busy_res || due.done_res) live_items++;
      if (typed_on && due.done_res) begin
         due.success = typed_ok;
         due.sample = typed_sample;
         due.config_value = typed_cfg;
      end
      pins_due.push_back(due);
   endtask

   // Issue a request and play the data line until the sequencer is idle again
   task automatic play_request(input logic [2:0] op, input logic [7:0] cfg, input int wait_hi,
                               input logic [23:0] word, input logic [7:0] rbyte);
      adctw_pkg::req_item_type it;
      int           highs;
      highs = 0;
      it.req_type = op;
      it.config_byte = cfg;
      it.dout_level = (highs < wait_hi);
      highs++;
      send_tick(it);
      while (seq_ph != adctw_pkg::PH_IDLE) begin
         // junk requests while busy must be ignored
         it.req_type = 3'($urandom_range(7));
         it.config_byte = 8'($urandom);
         it.dout_level = 1'($urandom);
         case (seq_ph)
            adctw_pkg::PH_WAIT: begin
               it.dout_level = (highs < wait_hi);
               highs++;
            end
            adctw_pkg::PH_FRAME: if (!in_high) it.dout_level = word[23 - bit_idx];
            adctw_pkg::PH_RBYTE: if (!in_high) it.dout_level = rbyte[7 - bit_idx];
            default: ;
         endcase
         send_tick(it);
      end
   endtask

   // Write a register once the block has drained, then read it back
   task automatic write_register(input logic [1:0] idx, input logic [19:0] val);
      logic [adctw_pkg::CSR_DATA_W-1:0] back;
      req_valid <= 1'b0;
      while (pins_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= adctw_pkg::CSR_ADDR_W'({idx, 2'b00});
      pwdata <= adctw_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         adctw_pkg::REG_TIMEOUT: timeout_cfg = val;
         adctw_pkg::REG_WR_CMD:  wr_cmd_cfg = val[6:0];
         adctw_pkg::REG_RD_CMD:  rd_cmd_cfg = val[6:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      back = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      check_field($sformatf("register %0d readback", idx),
                  adctw_pkg::CSR_DATA_W'(val), back);
   endtask

   initial begin
      int           base;
      int           wait_hi;
      int           n;
      logic [2:0]   op;
      logic [1:0]   reg_pick;
      logic [19:0]  v;
      adctw_pkg::req_item_type noise;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ignored codes while idle
      add_req(adctw_pkg::OP_NONE, 8'h00, 0, 24'h000000, 8'h00, 0, 0, 0, 0);
      add_req(OP_SPARE_FIRST, 8'hFF, 1, 24'h000000, 8'h00, 0, 0, 0, 0);
      add_req(OP_SPARE_LAST, 8'h55, 0, 24'h000000, 8'h00, 0, 0, 0, 0);
      // full-scale conversions
      add_req(adctw_pkg::OP_READ, 8'h00, 0, 24'h7FFFFF, 8'h00, 1, 1, 24'h7FFFFF, 8'h00);
      add_req(adctw_pkg::OP_READ, 8'hFF, 3, 24'h800000, 8'h00, 1, 1, 24'h800000, 8'h00);
      add_req(adctw_pkg::OP_READ_NB, 8'h00, 0, 24'h000000, 8'h00, 1, 1, 24'h000000, 8'h00);
      // not ready on the non-blocking read
      add_req(adctw_pkg::OP_READ_NB, 8'h00, 1, 24'h123456, 8'h00, 1, 0, 24'h000000, 8'h00);
      add_req(adctw_pkg::OP_READ_NB, 8'h00, 0, 24'hFFFFFF, 8'h00, 1, 1, 24'hFFFFFF, 8'h00);
      // zero timeout: fail at once unless already ready
      add_csr(adctw_pkg::REG_TIMEOUT, 20'd0);
      add_req(adctw_pkg::OP_READ, 8'h00, 1, 24'h5A5A5A, 8'h00, 1, 0, 24'h000000, 8'h00);
      add_req(adctw_pkg::OP_READ, 8'h00, 0, 24'hA5A5A5, 8'h00, 1, 1, 24'hA5A5A5, 8'h00);
      // one tick past the limit, then ready on the last allowed tick
      add_csr(adctw_pkg::REG_TIMEOUT, 20'd5);
      add_req(adctw_pkg::OP_READ, 8'h00, 6, 24'h000000, 8'h00, 1, 0, 24'h000000, 8'h00);
      add_req(adctw_pkg::OP_READ, 8'h00, 5, 24'h123456, 8'h00, 1, 1, 24'h123456, 8'h00);
      // configuration accesses with extreme command codes
      add_csr(adctw_pkg::REG_WR_CMD, 20'd0);
      add_csr(adctw_pkg::REG_RD_CMD, 20'd127);
      add_req(adctw_pkg::OP_WRITE_CFG, 8'hFF, 0, 24'hC3C3C3, 8'h00, 1, 1, 24'h000000, 8'h00);
      add_req(adctw_pkg::OP_READ_CFG, 8'h00, 2, 24'h3C3C3C, 8'hA5, 1, 1, 24'h000000, 8'hA5);
      add_csr(adctw_pkg::REG_WR_CMD, 20'd127);
      add_csr(adctw_pkg::REG_RD_CMD, 20'd0);
      add_req(adctw_pkg::OP_WRITE_CFG, 8'h00, 1, 24'hFFFFFF, 8'h00, 0, 0, 0, 0);
      add_req(adctw_pkg::OP_READ_CFG, 8'hFF, 0, 24'h000000, 8'h5A, 0, 0, 0, 0);
      add_csr(adctw_pkg::REG_TIMEOUT, 20'hFFFFF);
      add_req(adctw_pkg::OP_READ, 8'h00, 20, 24'h0F0F0F, 8'h00, 0, 0, 0, 0);
      add_req(adctw_pkg::OP_READ_CFG, 8'h00, 0, 24'h000000, 8'hFF, 1, 1, 24'h000000, 8'hFF);

      // walk the directed plan
      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_CSR) begin
            write_register(plan_rows[i].reg_idx, plan_rows[i].reg_val);
         end else begin
            typed_on = plan_rows[i].typed;
            typed_ok = plan_rows[i].exp_ok;
            typed_sample = plan_rows[i].exp_sample;
            typed_cfg = plan_rows[i].exp_cfg;
            play_request(plan_rows[i].op, plan_rows[i].cfg, plan_rows[i].wait_hi,
                         plan_rows[i].word, plan_rows[i].rbyte);
            typed_on = 1'b0;
         end
      end

      // random requests with occasional register changes between them
      base = live_items;
      while (live_items - base < RANDOM_ITEMS) begin
         gaps_enabled = !(live_items - base >= 200 && live_items - base < 350);
         if ($urandom_range(3) == 0) begin
            reg_pick = 2'($urandom_range(adctw_pkg::REG_RD_CMD));
            n = $urandom_range(3);
            if (reg_pick == adctw_pkg::REG_TIMEOUT)
               v = (n == 0) ? 20'd0 : (n == 1) ? 20'hFFFFF
                                               : 20'($urandom_range(MAX_TIMEOUT_TRIAL));
            else
               v = (n == 0) ? 20'd0 : (n == 1) ? 20'd127 : 20'($urandom_range(127));
            write_register(reg_pick, v);
         end
         // idle noise that the block should drop
         repeat ($urandom_range(2)) begin
            n = $urandom_range(3);
            noise.req_type = (n == 0) ? adctw_pkg::OP_NONE : 3'(adctw_pkg::OP_READ_CFG + n);
            noise.config_byte = 8'($urandom);
            noise.dout_level = 1'($urandom);
            send_tick(noise);
         end
         op = 3'($urandom_range(adctw_pkg::OP_READ, adctw_pkg::OP_READ_CFG));
         if (timeout_cfg <= MAX_TIMEOUT_TRIAL && $urandom_range(4) == 0)
            wait_hi = timeout_cfg + 1 + $urandom_range(3);
         else if ($urandom_range(1) == 0)
            wait_hi = 0;
         else
            wait_hi = $urandom_range(1, 8);
         play_request(op, 8'($urandom), wait_hi, 24'($urandom), 8'($urandom));
      end
      gaps_enabled = 1'b1;

      // drain and finish
      req_valid <= 1'b0;
      while (pins_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Receive results, stall at random, and guard the run length
   always @(posedge clock) begin : take_results
      adctw_pkg::rsp_item_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         rsp_stall <= gaps_enabled && ($urandom_range(99) < GAP_PERCENT);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pins_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing expected: %0h",
                           results_seen, rsp_data);
            end else begin
               want = pins_due.pop_front();
               check_field("sclk_level", want.sclk_level, rsp_data.sclk_level);
               check_field("data_drive_enable", want.data_drive_enable,
                           rsp_data.data_drive_enable);
               check_field("data_drive_value", want.data_drive_value,
                           rsp_data.data_drive_value);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("success", want.success, rsp_data.success);
               check_field("sample", want.sample, rsp_data.sample);
               check_field("config_value", want.config_value, rsp_data.config_value);
            end
            results_seen++;
         end
      end
   end

endmodule
